>>> hdl/sha256_stream_hasher_top_macros.svh
// ----------------------------------------------------------------------------
// SHA-256 hasher assertion macros
// Shared property macros for the port checker.
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_TOP_MACROS_SVH
`define SHA256_STREAM_HASHER_TOP_MACROS_SVH

// implication checked on every edge outside reset
`define SHS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define SHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hdl/shs_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Constants, types and round functions shared by the hasher modules.
// ----------------------------------------------------------------------------
package shs_pkg;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW = 2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last_byte;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_PAD,
		ST_OUT
	} state_t;

	localparam logic [255:0] IV = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] PAD_LIMIT = 6'd56;

	function automatic logic [31:0] iv_word(input logic [2:0] i);
		logic [31:0] w;
		w = IV[(7 - i) * 32 +: 32];
		return w;
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] k;
		case (t)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		logic [31:0] r;
		r = (x >> n) | (x << (32 - n));
		return r;
	endfunction

endpackage

>>> hdl/shs_front.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher front end
// Accepts input items, drops idle ones and queues the rest for the core.
// ----------------------------------------------------------------------------
module shs_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  shs_pkg::item_t in_item,
	output logic           q_valid,
	input  logic           q_ready,
	output shs_pkg::item_t q_item
);

	shs_pkg::item_t mem_q [shs_pkg::QDEPTH];
	logic [shs_pkg::QAW-1:0] wr_q, rd_q;
	logic [shs_pkg::QAW:0] cnt_q;
	logic push, pop, keep;

	assign in_ready = (cnt_q != 3'(shs_pkg::QDEPTH));
	assign keep = in_item.has_byte | in_item.last_byte;
	assign push = in_valid & in_ready & keep;
	assign q_valid = (cnt_q != '0);
	assign pop = q_valid & q_ready;
	assign q_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (push ? 3'd1 : 3'd0) - (pop ? 3'd1 : 3'd0);
		end
	end

endmodule

>>> hdl/shs_core.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher core
// Gathers bytes, pads, runs 64 rounds per block and emits the digest.
// ----------------------------------------------------------------------------
module shs_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_ready,
	input  shs_pkg::item_t q_item,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [31:0]    digest_word,
	output logic [2:0]     word_index,
	output logic           last_word
);

	shs_pkg::state_t state_q, state_d;
	logic [31:0] bw_q [16];
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [5:0]  fill_q;
	logic [63:0] len_q;
	logic [5:0]  rnd_q;
	logic [2:0]  oidx_q;
	logic        final_q;
	logic        second_q;
	logic        wrap_q;

	logic [31:0] w_new, t1, t2, w15, w2, s0, s1, b1, b0, ch, mj;

	always_comb begin
		w15 = w_q[4'(rnd_q + 6'd1)];
		w2 = w_q[4'(rnd_q + 6'd14)];
		s0 = shs_pkg::rotr(w15, 7) ^ shs_pkg::rotr(w15, 18) ^ (w15 >> 3);
		s1 = shs_pkg::rotr(w2, 17) ^ shs_pkg::rotr(w2, 19) ^ (w2 >> 10);
		if (rnd_q < 6'd16)
			w_new = bw_q[rnd_q[3:0]];
		else
			w_new = w_q[rnd_q[3:0]] + s0 + w_q[4'(rnd_q + 6'd9)] + s1;
		b1 = shs_pkg::rotr(v_q[4], 6) ^ shs_pkg::rotr(v_q[4], 11) ^ shs_pkg::rotr(v_q[4], 25);
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1 = v_q[7] + b1 + ch + shs_pkg::round_k(rnd_q) + w_new;
		b0 = shs_pkg::rotr(v_q[0], 2) ^ shs_pkg::rotr(v_q[0], 13) ^ shs_pkg::rotr(v_q[0], 22);
		mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2 = b0 + mj;
	end

	always_comb begin
		state_d = state_q;
		q_ready = 1'b0;
		case (state_q)
			shs_pkg::ST_IDLE: begin
				q_ready = 1'b1;
				if (q_valid) begin
					if (q_item.has_byte && fill_q == 6'd63) state_d = shs_pkg::ST_ROUND;
					else if (q_item.last_byte) state_d = shs_pkg::ST_PAD;
				end
			end
			shs_pkg::ST_ROUND: if (rnd_q == 6'd63) state_d = shs_pkg::ST_ADD;
			shs_pkg::ST_ADD: begin
				if (!final_q) state_d = shs_pkg::ST_IDLE;
				else if (second_q || wrap_q) state_d = shs_pkg::ST_PAD;
				else state_d = shs_pkg::ST_OUT;
			end
			shs_pkg::ST_PAD: state_d = shs_pkg::ST_ROUND;
			shs_pkg::ST_OUT: if (out_ready && oidx_q == 3'd7) state_d = shs_pkg::ST_IDLE;
			default: state_d = shs_pkg::ST_IDLE;
		endcase
	end

	assign out_valid = (state_q == shs_pkg::ST_OUT);
	assign digest_word = h_q[oidx_q];
	assign word_index = oidx_q;
	assign last_word = (oidx_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= shs_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (state_q == shs_pkg::ST_IDLE && q_valid && q_item.has_byte)
			bw_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= q_item.data_byte;
		if (state_q == shs_pkg::ST_PAD) begin
			for (int i = 0; i < 64; i++) begin
				if (i >= 56 && (second_q || fill_q < shs_pkg::PAD_LIMIT))
					bw_q[4'(i >> 2)][(3 - (i & 3)) * 8 +: 8] <= len_q[(63 - i) * 8 +: 8];
				else if (second_q) bw_q[4'(i >> 2)][(3 - (i & 3)) * 8 +: 8] <= 8'h00;
				else if (6'(i) == fill_q)
					bw_q[4'(i >> 2)][(3 - (i & 3)) * 8 +: 8] <= shs_pkg::PAD_MARK;
				else if (6'(i) > fill_q) bw_q[4'(i >> 2)][(3 - (i & 3)) * 8 +: 8] <= 8'h00;
			end
		end
		if (state_q == shs_pkg::ST_ROUND) begin
			w_q[rnd_q[3:0]] <= w_new;
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
		if (state_d == shs_pkg::ST_ROUND && state_q != shs_pkg::ST_ROUND)
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) h_q[i] <= shs_pkg::iv_word(3'(i));
			fill_q <= '0;
			len_q <= '0;
			rnd_q <= '0;
			oidx_q <= '0;
			final_q <= 1'b0;
			second_q <= 1'b0;
			wrap_q <= 1'b0;
		end else begin
			case (state_q)
				shs_pkg::ST_IDLE: if (q_valid) begin
					if (q_item.has_byte) begin
						fill_q <= fill_q + 6'd1;
						len_q <= len_q + 64'd8;
					end
					final_q <= q_item.last_byte;
					second_q <= 1'b0;
					wrap_q <= q_item.has_byte && q_item.last_byte && fill_q == 6'd63;
					rnd_q <= '0;
				end
				shs_pkg::ST_ROUND: rnd_q <= rnd_q + 6'd1;
				shs_pkg::ST_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					if (final_q && second_q) second_q <= 1'b1;
					wrap_q <= 1'b0;
				end
				shs_pkg::ST_PAD: begin
					rnd_q <= '0;
					second_q <= !second_q && fill_q >= shs_pkg::PAD_LIMIT;
					if (second_q) fill_q <= '0;
				end
				shs_pkg::ST_OUT: if (out_ready) begin
					oidx_q <= oidx_q + 3'd1;
					if (oidx_q == 3'd7) begin
						for (int i = 0; i < 8; i++) h_q[i] <= shs_pkg::iv_word(3'(i));
						fill_q <= '0;
						len_q <= '0;
						final_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

>>> hdl/sha256_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher top level
// Byte stream in, eight digest words out per message.
// ----------------------------------------------------------------------------
// channel  dir  tdata                 tuser                  tlast
// s_axis   in   data_byte[7:0]        has_byte               last_byte
// m_axis   out  digest_word[31:0]     word_index[2:0]        last_word
//
// The core takes bytes only while idle; every 64th byte starts the 64-round
// compression loop. The end item adds one or two blocks plus the eight
// output words. A four-item queue decouples input from the core.
// Reset is asynchronous and clears control state and the hash to its
// initial values; output stalls hold the core.
module sha256_stream_hasher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // data_byte
	input  logic        s_axis_tuser,  // has_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // digest_word
	output logic [2:0]  m_axis_tuser,  // word_index
	output logic        m_axis_tlast
);

	shs_pkg::item_t in_item, q_item;
	logic q_valid, q_ready;

	assign in_item.data_byte = s_axis_tdata;
	assign in_item.has_byte = s_axis_tuser;
	assign in_item.last_byte = s_axis_tlast;

	shs_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
	);

	shs_core u_core (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.digest_word(m_axis_tdata), .word_index(m_axis_tuser), .last_word(m_axis_tlast)
	);

endmodule

>>> hdl/shs_checker.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher port checker
// Port-level properties of the digest stream.
// ----------------------------------------------------------------------------
`include "sha256_stream_hasher_top_macros.svh"

module shs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [2:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	`SHS_ASSERT_IMPL(a_last_idx, clk, arst_n, m_axis_tvalid, m_axis_tlast == (m_axis_tuser == 3'd7))
	`SHS_ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	`SHS_ASSERT_NEXT(a_step, clk, arst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1)
	`SHS_ASSERT_NEXT(a_gap, clk, arst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid)

endmodule

bind sha256_stream_hasher_top shs_checker u_chk (
	.clk(clk), .arst_n(arst_n), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
);

>>> test/tb_sha256_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Drives byte items over the input stream, computes each digest with its own
// SHA-256 predictor and compares every output word field by field, under
// several sender and receiver idling phases and a long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sha256_stream_hasher_top;

	typedef struct {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last_byte;
	} byte_item_t;

	typedef struct {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_out_t;

	localparam int WATCHDOG_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;  // data_byte
	logic        s_axis_tuser;  // has_byte
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;  // digest_word
	logic [2:0]  m_axis_tuser;  // word_index
	logic        m_axis_tlast;

	sha256_stream_hasher_top dut (.*);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	// predictor state
	logic [31:0] hw[8];
	logic [7:0]  blk[64];
	int unsigned fill;
	logic [63:0] bit_len;
	logic [31:0] kt[64];

	byte_item_t  pending_bytes[$];
	digest_out_t expected_words[$];
	int          send_idle_pct, recv_stall_pct, hold_cycles;
	bit          pause_send, stim_done;
	int          mismatches, words_seen, messages_sent, items_sent, idle_cnt;

	function automatic logic [31:0] ror(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic digest_reset();
		hw = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		fill = 0;
		bit_len = '0;
	endtask

	task automatic compress();
		logic [31:0] w[64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
		for (int t = 0; t < 16; t++)
			w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
		for (int t = 16; t < 64; t++)
			w[t] = w[t-16] + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3))
				+ w[t-7] + (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10));
		{a, b, c, d, e, f, g, h} = {hw[0], hw[1], hw[2], hw[3], hw[4], hw[5], hw[6], hw[7]};
		for (int t = 0; t < 64; t++) begin
			t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) + kt[t] + w[t];
			t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
		end
		hw[0] += a; hw[1] += b; hw[2] += c; hw[3] += d;
		hw[4] += e; hw[5] += f; hw[6] += g; hw[7] += h;
	endtask

	task automatic predict_digest(byte_item_t it);
		digest_out_t o;
		if (it.has_byte) begin
			blk[fill] = it.data_byte;
			fill++;
			bit_len += 64'd8;
			if (fill == 64) begin
				compress();
				fill = 0;
			end
		end
		if (!it.last_byte)
			return;
		blk[fill] = 8'h80;
		for (int i = fill + 1; i < 64; i++)
			blk[i] = 8'h00;
		if (fill >= 56) begin
			compress();
			for (int i = 0; i < 64; i++)
				blk[i] = 8'h00;
		end
		for (int i = 0; i < 8; i++)
			blk[63-i] = bit_len[i*8 +: 8];
		compress();
		for (int i = 0; i < 8; i++) begin
			o.digest_word = hw[i];
			o.word_index = 3'(i);
			o.last_word = (i == 7);
			expected_words = {expected_words, o};
		end
		digest_reset();
	endtask

	task automatic queue_byte(logic [7:0] d, logic hb, logic lb);
		byte_item_t it;
		it.data_byte = d;
		it.has_byte = hb;
		it.last_byte = lb;
		pending_bytes = {pending_bytes, it};
	endtask

	task automatic queue_message(int len, bit end_only, int fill_mode);
		logic [7:0] d;
		for (int i = 0; i < len; i++) begin
			d = (fill_mode == 1) ? 8'hff : (fill_mode == 2) ? 8'h00 : 8'($urandom);
			if (!end_only && i == len - 1)
				queue_byte(d, 1'b1, 1'b1);
			else
				queue_byte(d, 1'b1, 1'b0);
			if ($urandom_range(0, 19) == 0)
				queue_byte(8'($urandom), 1'b0, 1'b0);
		end
		if (end_only || len == 0)
			queue_byte(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic wait_drain();
		while (pending_bytes.size() != 0 || expected_words.size() != 0)
			@(posedge clk);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= 1'b0;
			s_axis_tlast <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_digest(pending_bytes.pop_front());
				items_sent++;
			end
			if ((s_axis_tvalid && !s_axis_tready) ||
				(pending_bytes.size() != 0 && !pause_send &&
				$urandom_range(0, 99) >= send_idle_pct)) begin
				if (!(s_axis_tvalid && !s_axis_tready)) begin
					s_axis_tdata <= pending_bytes[0].data_byte;
					s_axis_tuser <= pending_bytes[0].has_byte;
					s_axis_tlast <= pending_bytes[0].last_byte;
				end
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// monitor and receiver
	always @(posedge clk or negedge arst_n) begin
		digest_out_t e;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				words_seen++;
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected word %h idx %0d last %b",
							m_axis_tdata, m_axis_tuser, m_axis_tlast);
				end else begin
					e = expected_words.pop_front();
					if (e.digest_word !== m_axis_tdata || e.word_index !== m_axis_tuser ||
						e.last_word !== m_axis_tlast) begin
						mismatches++;
						if (mismatches <= 10)
							$display("word mismatch: exp %h/%0d/%b got %h/%0d/%b",
								e.digest_word, e.word_index, e.last_word,
								m_axis_tdata, m_axis_tuser, m_axis_tlast);
					end
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !arst_n)
			idle_cnt <= 0;
		else if (!stim_done || expected_words.size() != 0)
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WATCHDOG_LIMIT) begin
			$display("watchdog expired");
			$display("sha256_stream_hasher_top: mismatch");
			$finish;
		end
	end

	initial begin
		kt = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
			32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
			32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
			32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
			32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
			32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		digest_reset();
		for (int i = 0; i < 64; i++)
			blk[i] = 8'h00;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		pause_send = 1'b0;
		stim_done = 1'b0;
		mismatches = 0;
		words_seen = 0;
		items_sent = 0;
		messages_sent = 0;
		idle_cnt = 0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: idle items, empty message, byte extremes, end-only after bytes
		queue_byte(8'h00, 1'b0, 1'b0);
		queue_byte(8'hff, 1'b0, 1'b0);
		queue_byte(8'h00, 1'b0, 1'b1);
		queue_byte(8'h00, 1'b1, 1'b1);
		queue_byte(8'hff, 1'b1, 1'b1);
		queue_byte(8'h61, 1'b1, 1'b0);
		queue_byte(8'h62, 1'b1, 1'b0);
		queue_byte(8'h63, 1'b1, 1'b1);
		queue_byte(8'h5a, 1'b1, 1'b0);
		queue_byte(8'ha5, 1'b1, 1'b0);
		queue_byte(8'hff, 1'b0, 1'b1);
		messages_sent = 5;
		wait_drain();

		// padding boundaries: 55, 56 and 64 bytes, the last ending on a full block
		queue_message(55, 0, 1);
		queue_message(56, 0, 2);
		queue_message(64, 0, 0);
		messages_sent += 3;

		// receiver holds off while the sender keeps offering
		hold_cycles = 600;
		queue_message(3, 0, 0);
		queue_message(2, 0, 0);
		queue_message(4, 1, 0);
		messages_sent += 3;
		wait_drain();

		// random phases: idle/stall percentages per phase
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 15 : 45) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 15 : 45) : 0;
			for (int m = 0; m < 2; m++) begin
				queue_message($urandom_range(0, 3), $urandom_range(0, 3) == 0, 0);
				messages_sent++;
			end
			wait_drain();
			// sender pauses once every result is in
			pause_send = 1'b1;
			repeat ($urandom_range(5, 40)) @(posedge clk);
			pause_send = 1'b0;
		end

		stim_done = 1'b1;
		repeat (200) @(posedge clk);
		$display("covered %0d input items in %0d messages, %0d digest words checked",
			items_sent, messages_sent, words_seen);
		$display("idle items, empty and end-only messages, pad boundaries, long hold-off");
		if (mismatches == 0 && expected_words.size() == 0)
			$display("sha256_stream_hasher_top: match");
		else
			$display("sha256_stream_hasher_top: mismatch");
		$finish;
	end

endmodule
